// ===== hdl/gptaper_pkg.sv =====
// ----------------------------------------------------------------------------
// gptaper_pkg
// Shared types, constants and exponential tables for the Gaussian post-pick
// taper: payload structs, configuration, queue entry and ROM contents.
// ----------------------------------------------------------------------------
package gptaper_pkg;

	localparam int MAX_SAMPLES    = 65536;
	localparam int EXP_TABLE_BITS = 8;
	localparam int EXP_INT_RANGE  = 24;
	localparam int FRAC_SHIFT     = 32 - EXP_TABLE_BITS;
	localparam int FRAC_SIZE      = (1 << EXP_TABLE_BITS) + 1;
	localparam int CNT_W          = $clog2(MAX_SAMPLES + 1);
	localparam int INT_IDX_W      = $clog2(EXP_INT_RANGE);
	localparam int QUEUE_DEPTH    = 4;
	localparam int BACK_DEPTH     = 11;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_FWD_PICK,
		MODE_CONST,
		MODE_REV_PICK
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_MODE,
		REG_SAMPLE_INTERVAL,
		REG_DAMPING_GAIN,
		REG_WINDOW_START,
		REG_SAMPLES_PER_TRACE
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic signed [31:0] pick_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] scaled_value;
		logic               trace_end;
	} out_item_t;

	typedef struct packed {
		mode_t              window_mode;
		logic [30:0]        sample_interval;
		logic [31:0]        damping_gain;
		logic signed [31:0] window_start;
		logic [16:0]        samples_per_trace;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic signed [31:0] pick_time;
		logic [CNT_W-1:0]   count;
		logic               last;
	} q_item_t;

	localparam logic [30:0] RST_SAMPLE_INTERVAL   = 31'd16777;
	localparam logic [31:0] RST_DAMPING_GAIN      = 32'd65536;
	localparam logic [16:0] RST_SAMPLES_PER_TRACE = 17'd1024;

	typedef logic [30:0] frac_tab_t [FRAC_SIZE];
	typedef logic [30:0] int_tab_t [EXP_INT_RANGE];

	// long division, used only while building the tables
	function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-k/2^bits) in Q.30 from the series of exp(+k/2^bits)
	function automatic frac_tab_t build_frac();
		frac_tab_t   tab;
		logic [63:0] sum;
		logic [63:0] term;
		for (int k = 0; k < FRAC_SIZE; k++) begin
			sum  = '0;
			term = 64'd1 << 32;
			for (int n = 1; n < 64; n++) begin
				sum  = sum + term;
				term = const_udiv((term * 64'(k)) >> EXP_TABLE_BITS, 64'(n));
			end
			tab[k] = 31'(const_udiv((64'd1 << 62) + (sum >> 1), sum));
		end
		return tab;
	endfunction

	localparam frac_tab_t TAB_FRAC = build_frac();

	// exp(-n) in Q.30
	function automatic int_tab_t build_int(input logic [30:0] step);
		int_tab_t    tab;
		logic [63:0] p;
		tab[0] = 31'd1 << 30;
		for (int n = 1; n < EXP_INT_RANGE; n++) begin
			p      = 64'(tab[n-1]) * 64'(step) + (64'd1 << 29);
			tab[n] = p[60:30];
		end
		return tab;
	endfunction

	localparam int_tab_t TAB_INT = build_int(TAB_FRAC[FRAC_SIZE-1]);

endpackage

// ===== hdl/gaussian_post_pick_taper_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_post_pick_taper_top
// Gaussian time damping of seismic trace samples after a picked onset.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one trace sample and its trace's pick time per transaction,
//   streamed trace after trace; the internal counter marks trace boundaries.
//   result channel: the tapered sample and a trace_end flag on the last sample.
//   cfg port: write enable, register index and data; write only while idle.
// Throughput: one sample per cycle; the front end takes a sample each cycle
//   the four-entry queue has room, the back end retires one per cycle unless
//   result_ready is low.
// Path: a sample passes through its queue slot, then ten arithmetic stages
//   (three 32x32 products, table lookup, interpolation product and two
//   rounding products) before it reaches the result register.
// Reset: registers return to pass mode and their defaults, the sample counter
//   restarts at the first sample of a trace, sample_ready stays low until the
//   first clock after reset is released.
// Stall: when result_ready is low with a result shown, the back end holds;
//   the queue keeps taking samples until it is full, then sample_ready drops.
// ----------------------------------------------------------------------------
module gaussian_post_pick_taper_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  gptaper_pkg::in_item_t                sample_item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output gptaper_pkg::out_item_t               result_item,
	input  logic                                 cfg_we,
	input  logic [gptaper_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gptaper_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gptaper_pkg::*;

	cfg_t    cfg_q;
	logic    q_push;
	q_item_t q_item;
	logic    q_full;
	logic    q_pop;
	logic    q_empty;
	q_item_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_mode       <= MODE_PASS;
			cfg_q.sample_interval   <= RST_SAMPLE_INTERVAL;
			cfg_q.damping_gain      <= RST_DAMPING_GAIN;
			cfg_q.window_start      <= '0;
			cfg_q.samples_per_trace <= RST_SAMPLES_PER_TRACE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_MODE: begin
					cfg_q.window_mode <= mode_t'(cfg_data[1:0]);
				end
				REG_SAMPLE_INTERVAL: begin
					cfg_q.sample_interval <= cfg_data[30:0];
				end
				REG_DAMPING_GAIN: begin
					cfg_q.damping_gain <= cfg_data;
				end
				REG_WINDOW_START: begin
					cfg_q.window_start <= $signed(cfg_data);
				end
				REG_SAMPLES_PER_TRACE: begin
					cfg_q.samples_per_trace <= cfg_data[16:0];
				end
				default: begin
				end
			endcase
		end
	end

	gptaper_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_item  (sample_item),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	gptaper_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	gptaper_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_head       (q_head),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

// ===== hdl/gptaper_queue.sv =====
// ----------------------------------------------------------------------------
// gptaper_queue
// Small register queue between the sample counter front end and the
// arithmetic back end.
// ----------------------------------------------------------------------------
module gptaper_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  gptaper_pkg::q_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output gptaper_pkg::q_item_t head
);
	import gptaper_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	q_item_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [FILL_W-1:0] fill_q;

	assign full  = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

// ===== hdl/gptaper_front.sv =====
// ----------------------------------------------------------------------------
// gptaper_front
// Accepts samples, runs the per-trace sample counter and tags each sample
// with its time count and end-of-trace flag.
// ----------------------------------------------------------------------------
module gptaper_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gptaper_pkg::cfg_t     cfg,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  gptaper_pkg::in_item_t sample_item,
	input  logic                  q_full,
	output logic                  q_push,
	output gptaper_pkg::q_item_t  q_item
);
	import gptaper_pkg::*;

	logic             run_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] ns;
	logic [CNT_W-1:0] count;
	logic [31:0]      spt_w;
	logic             last;

	always_comb begin
		spt_w = 32'(cfg.samples_per_trace);
		if (spt_w == '0) begin
			ns = CNT_W'(1);
		end else if (spt_w > 32'(MAX_SAMPLES)) begin
			ns = CNT_W'(MAX_SAMPLES);
		end else begin
			ns = CNT_W'(spt_w);
		end
		last = (idx_q >= ns);
		if (cfg.window_mode == MODE_REV_PICK) begin
			count = (idx_q <= ns) ? (ns - idx_q + CNT_W'(1)) : CNT_W'(1);
		end else begin
			count = idx_q;
		end
	end

	assign sample_ready = run_q && !q_full;
	assign q_push       = sample_valid && sample_ready;

	always_comb begin
		q_item.sample_value = sample_item.sample_value;
		q_item.pick_time    = sample_item.pick_time;
		q_item.count        = count;
		q_item.last         = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= CNT_W'(1);
		end else begin
			run_q <= 1'b1;
			if (q_push) begin
				idx_q <= last ? CNT_W'(1) : idx_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/gptaper_back.sv =====
// ----------------------------------------------------------------------------
// gptaper_back
// Stall pipeline that forms the Gaussian taper for each queued sample and
// applies it from the onset outside pass mode: time, offset square, damping
// exponent, table lookup with interpolation, scaled sample in output register.
// ----------------------------------------------------------------------------
module gptaper_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gptaper_pkg::cfg_t      cfg,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  gptaper_pkg::q_item_t   q_head,
	output logic                   result_valid,
	input  logic                   result_ready,
	output gptaper_pkg::out_item_t result_item
);
	import gptaper_pkg::*;

	localparam int TU_W   = CNT_W + 31;
	localparam int PROD_W = 31 + FRAC_SHIFT;
	localparam int FIDX_W = EXP_TABLE_BITS + 1;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               last;
		logic               apply;
	} carry_t;

	logic [BACK_DEPTH-1:0] vld_q;
	carry_t                line_q [BACK_DEPTH-1];
	logic                  adv;

	logic [TU_W-1:0]       tu_s1;
	logic signed [31:0]    pick_s1;
	logic [31:0]           mag_s2;
	logic [63:0]           d2_s3;
	logic [63:0]           phi_s4;
	logic [63:0]           plo_s4;
	logic [63:0]           x_s5;
	logic [30:0]           a_s6;
	logic [30:0]           b_s6;
	logic [FRAC_SHIFT-1:0] w_s6;
	logic [30:0]           tint_s6;
	logic [PROD_W-1:0]     prod_s7;
	logic [30:0]           a_s7;
	logic                  down_s7;
	logic [30:0]           tint_s7;
	logic [30:0]           lin_s8;
	logic [30:0]           tint_s8;
	logic [30:0]           t_s9;
	logic [31:0]           pm_s10;
	out_item_t             out_q;

	logic [30:0]           time_c;
	logic signed [31:0]    ref_c;
	logic signed [31:0]    onset_c;
	logic                  apply_c;
	logic signed [33:0]    d_c;
	logic signed [33:0]    nd_c;
	logic [31:0]           mag_c;
	logic                  zero_c;
	logic [INT_IDX_W-1:0]  nidx_c;
	logic [FIDX_W-1:0]     fidx_c;
	logic                  down_c;
	logic [30:0]           diff_c;
	logic [30:0]           step_c;
	logic [63:0]           tl_c;
	logic [31:0]           smag_c;
	logic [63:0]           pm_c;
	logic signed [31:0]    res_c;

	assign adv          = !vld_q[BACK_DEPTH-1] || result_ready;
	assign q_pop        = adv && !q_empty;
	assign result_valid = vld_q[BACK_DEPTH-1];
	assign result_item  = out_q;

	always_comb begin
		time_c = (|tu_s1[TU_W-1:31]) ? 31'h7FFF_FFFF : tu_s1[30:0];
		if (cfg.window_mode == MODE_CONST) begin
			ref_c   = 32'sd0 - $signed({1'b0, cfg.sample_interval});
			onset_c = cfg.window_start;
		end else begin
			ref_c   = pick_s1;
			onset_c = pick_s1;
		end
		apply_c = (cfg.window_mode != MODE_PASS) &&
			($signed({2'b00, time_c}) >= $signed({onset_c[31], onset_c}));
		d_c   = $signed({3'b000, time_c}) - $signed({{2{ref_c[31]}}, ref_c});
		nd_c  = 34'sd0 - d_c;
		mag_c = d_c[33] ? nd_c[31:0] : d_c[31:0];

		zero_c = (x_s5[63:32] >= 32'(EXP_INT_RANGE));
		nidx_c = zero_c ? '0 : x_s5[32 +: INT_IDX_W];
		fidx_c = {1'b0, x_s5[31 -: EXP_TABLE_BITS]};

		down_c = (a_s6 >= b_s6);
		diff_c = down_c ? (a_s6 - b_s6) : (b_s6 - a_s6);

		step_c = prod_s7[FRAC_SHIFT +: 31];

		tl_c = 64'(tint_s8) * 64'(lin_s8) + (64'd1 << 29);

		smag_c = line_q[8].sample[31] ? (32'd0 - line_q[8].sample) : line_q[8].sample;
		pm_c   = 64'(smag_c) * 64'(t_s9) + (64'd1 << 29);

		if (!line_q[9].apply) begin
			res_c = line_q[9].sample;
		end else if (line_q[9].sample[31]) begin
			res_c = 32'sd0 - $signed(pm_s10);
		end else begin
			res_c = $signed(pm_s10);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[BACK_DEPTH-2:0], !q_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			line_q[0] <= '{sample: q_head.sample_value, last: q_head.last, apply: 1'b0};
			line_q[1] <= '{sample: line_q[0].sample, last: line_q[0].last, apply: apply_c};
			for (int i = 2; i < BACK_DEPTH - 1; i++) begin
				line_q[i] <= line_q[i-1];
			end

			tu_s1   <= TU_W'(q_head.count) * TU_W'(cfg.sample_interval);
			pick_s1 <= q_head.pick_time;

			mag_s2 <= mag_c;

			d2_s3 <= 64'(mag_s2) * 64'(mag_s2);

			phi_s4 <= 64'(cfg.damping_gain) * 64'(d2_s3[63:32]);
			plo_s4 <= 64'(cfg.damping_gain) * 64'(d2_s3[31:0]);

			x_s5 <= phi_s4 + {32'd0, plo_s4[63:32]};

			a_s6    <= TAB_FRAC[fidx_c];
			b_s6    <= TAB_FRAC[fidx_c + FIDX_W'(1)];
			w_s6    <= x_s5[FRAC_SHIFT-1:0];
			tint_s6 <= zero_c ? '0 : TAB_INT[nidx_c];

			prod_s7 <= PROD_W'(diff_c) * PROD_W'(w_s6);
			a_s7    <= a_s6;
			down_s7 <= down_c;
			tint_s7 <= tint_s6;

			lin_s8  <= down_s7 ? (a_s7 - step_c) : (a_s7 + step_c);
			tint_s8 <= tint_s7;

			t_s9 <= tl_c[60:30];

			pm_s10 <= pm_c[61:30];

			out_q.scaled_value <= res_c;
			out_q.trace_end    <= line_q[9].last;
		end
	end

endmodule

// ===== hdl/gptaper_checker.sv =====
// ----------------------------------------------------------------------------
// gptaper_checker
// Port-level checks for the taper block: transaction balance between the
// two channels, reset behavior and result hold under stall.
// ----------------------------------------------------------------------------
module gptaper_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   sample_valid,
	input logic                   sample_ready,
	input logic                   result_valid,
	input logic                   result_ready,
	input gptaper_pkg::out_item_t result_item
);
	import gptaper_pkg::*;

	localparam int CAP   = QUEUE_DEPTH + BACK_DEPTH;
	localparam int OUT_W = $clog2(CAP + 2);

	logic             in_xact;
	logic             out_xact;
	logic [OUT_W-1:0] pend_q;

	assign in_xact  = sample_valid && sample_ready;
	assign out_xact = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xact && !out_xact) begin
			pend_q <= pend_q + OUT_W'(1);
		end else if (out_xact && !in_xact) begin
			pend_q <= pend_q - OUT_W'(1);
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != '0)
		else $error("result shown with no sample outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= OUT_W'(CAP))
		else $error("more samples held than the block can store");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !result_valid && !sample_ready)
		else $error("activity in the first cycle after reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("result changed while stalled");

endmodule

bind gaussian_post_pick_taper_top gptaper_checker u_gptaper_checker (.*);
